### rtl/core/gsd_pkg.sv
package gsd_pkg;

  // Number of entries in the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classification that the front attaches to every queued item.
  typedef struct packed {
    logic has_diff;  // a difference to the previous value exists
    logic last;      // the item closes its sequence
  } gsd_ctl_t;

  // Back-end sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } gsd_state_e;

  // Back-end status, seen by the top level.
  typedef struct packed {
    logic idle;
    logic run;
    logic emit;
  } gsd_bstat_t;

endpackage

### rtl/core/gsd_front.sv
module gsd_front import gsd_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [W-1:0] value_i,
  input  logic                last_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output logic [W-1:0]        q_diff_o,
  output gsd_ctl_t            q_ctl_o
);

  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] prev_q, prev_d;
  logic         have_prev_q, have_prev_d;
  logic [W-1:0] cur_biased;
  logic [W-1:0] prev_biased;

  // The front stalls only when the queue has no room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Flipping the sign bit maps signed order onto unsigned order.
  assign cur_biased  = value_i ^ SignBit;
  assign prev_biased = prev_q ^ SignBit;

  // Absolute difference; it always fits in W unsigned bits.
  always_comb begin
    if (cur_biased >= prev_biased) begin
      q_diff_o = cur_biased - prev_biased;
    end else begin
      q_diff_o = prev_biased - cur_biased;
    end
  end

  assign q_ctl_o.has_diff = have_prev_q;
  assign q_ctl_o.last     = last_i;

  // Previous value tracking; a last item restarts the sequence.
  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    if (q_push_o) begin
      prev_d      = value_i;
      have_prev_d = !last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

### rtl/core/gsd_queue.sv
module gsd_queue import gsd_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_diff_i,
  input  gsd_ctl_t     push_ctl_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_diff_o,
  output gsd_ctl_t     pop_ctl_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EntW = W + $bits(gsd_ctl_t);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [EntW-1:0] entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic [EntW-1:0] rd_entry;

  assign full_o   = (cnt_q == FullCnt);
  assign valid_o  = (cnt_q != '0);
  assign rd_entry = entry_q[rd_ptr_q];
  assign pop_diff_o = rd_entry[W-1:0];
  assign pop_ctl_o  = gsd_ctl_t'(rd_entry[EntW-1:W]);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= {push_ctl_i, push_diff_i};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/gsd_back.sv
module gsd_back import gsd_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  logic [W-1:0] q_diff_i,
  input  gsd_ctl_t     q_ctl_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [W-1:0] divisor_o,
  output gsd_bstat_t   stat_o
);

  localparam int unsigned KW = (W > 2) ? $clog2(W) : 1;

  gsd_state_e   state_q, state_d;
  logic [W-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic         last_q, last_d;
  logic [W-1:0] run_q, run_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] divisor_q, divisor_d;
  logic         out_free;
  logic         gcd_done;
  logic [W-1:0] gcd_res;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign divisor_o   = divisor_q;

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.run  = (state_q == ST_RUN);
  assign stat_o.emit = (state_q == ST_EMIT);

  // Binary GCD finishes once either operand reaches zero.
  assign gcd_done = (a_q == '0) || (b_q == '0);
  assign gcd_res  = ((a_q == '0) ? b_q : a_q) << k_q;

  // Sequencer: one binary GCD step per cycle in the run state.
  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    k_d         = k_q;
    last_d      = last_q;
    run_d       = run_q;
    divisor_d   = divisor_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          last_d  = q_ctl_i.last;
          if (q_ctl_i.has_diff) begin
            a_d     = q_diff_i;
            b_d     = run_q;
            k_d     = '0;
            state_d = ST_RUN;
          end else if (q_ctl_i.last) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_RUN: begin
        if (gcd_done) begin
          run_d   = gcd_res;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = (a_q - b_q) >> 1;
        end else begin
          b_d = (b_q - a_q) >> 1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          divisor_d   = run_q;
          out_valid_d = 1'b1;
          run_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    b_q       <= b_d;
    k_q       <= k_d;
    last_q    <= last_d;
    divisor_q <= divisor_d;
  end

endmodule

### rtl/core/gcd_of_successive_differences_top.sv
// Channel | Handshake                  | Fields
// input   | in_valid_i / in_stall_o    | value_i (signed), last_i
// output  | out_valid_o / out_stall_i  | divisor_o (unsigned)
//
// The front takes an item per cycle while the two-entry queue has room.
// The back folds each difference into the running GCD with a binary GCD
// unit, one step a cycle; it pops each item first and, on a last item,
// loads the output register once the GCD is done.
// Reset is asynchronous and clears the sequence state; no sweep follows.
// An output stall holds only the back; the front keeps filling the queue.
module gcd_of_successive_differences_top import gsd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VALUE_WIDTH-1:0]        divisor_o
);

  logic                   push;
  logic [VALUE_WIDTH-1:0] push_diff;
  gsd_ctl_t               push_ctl;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [VALUE_WIDTH-1:0] q_diff;
  gsd_ctl_t               q_ctl;
  gsd_bstat_t             bstat;

  // Front: difference to the previous value and item classification.
  gsd_front #(.W(VALUE_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .q_push_o   (push),
    .q_diff_o   (push_diff),
    .q_ctl_o    (push_ctl)
  );

  // Queue between front and back.
  gsd_queue #(.W(VALUE_WIDTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_diff_i (push_diff),
    .push_ctl_i  (push_ctl),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_diff_o  (q_diff),
    .pop_ctl_o   (q_ctl)
  );

  // Back: iterative GCD and result register.
  gsd_back #(.W(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_diff_i    (q_diff),
    .q_ctl_i     (q_ctl),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .divisor_o   (divisor_o),
    .stat_o      (bstat)
  );

  // A taken result is not repeated unless a new one is being loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !bstat.emit) |=> !out_valid_o)
    else $error("result repeated after it was taken");

  // A popped last item always leads toward emitting a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_ctl.last) |=> (bstat.emit || bstat.run))
    else $error("last item did not lead to a result");

  // A first item of a longer sequence needs no GCD work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && !q_ctl.has_diff && !q_ctl.last) |=> bstat.idle)
    else $error("first item started GCD work");

endmodule
